>>> hdl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros shared by the checker of the signed integer to decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define SIDA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sida checker: same-cycle property failed");

// Check that a condition implies another in the next cycle
`define SIDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sida checker: next-cycle property failed");

`endif

>>> hdl/sida_pkg.sv
// Package of the signed integer to decimal text converter: constants and shared types
package sida_pkg;

    // Default width of the signed input value
    localparam int VALUE_BITS_DEFAULT = 32;

    // One BCD digit
    localparam int DIGIT_BITS = 4;

    // ASCII character codes and their width on the result channel
    localparam int        CHAR_BITS   = 6;
    localparam int        M_TDATA_BITS = 8;
    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

    // Handover status from the converter to the character emitter
    typedef struct packed {
        logic done;
        logic negative;
    } conv_status_t;

endpackage

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter
//
//  Channel | Direction | Carries
//  s_      | in        | tdata: number (VALUE_BITS, signed), zero padded to bytes
//  m_      | out       | tdata: char_code (6 bits) + 2 zero bits; tlast: last_char
//
//  Conversion: the magnitude is loaded, shifted through the add-3 digits bit by bit and
//  held until the emitter takes the digits; only then is the next number accepted.
//  Emission: load the digits, drop leading zeros, leave the skip state, then send the
//  sign of a negative number and each digit, the last one flagged with tlast.
//  The converter takes the next number while the emitter still sends the last one.
//  A stall on m_tready holds the output register and backs up into s_tready.
//  Reset (aresetn low, synchronous) clears both controllers and the output valid.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,  // [VALUE_BITS-1:0] number
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sida_pkg::M_TDATA_BITS-1:0]     m_tdata,  // [5:0] char_code
    output logic                                  m_tlast
);

    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    sida_pkg::conv_status_t                 status;
    logic [DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd;
    logic                                   take;
    logic                                   conv_ready;
    logic [sida_pkg::CHAR_BITS-1:0]         char_code;

    assign s_tready = conv_ready;

    sida_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_tvalid && conv_ready),
        .number  (s_tdata[VALUE_BITS-1:0]),
        .ready   (conv_ready),
        .status  (status),
        .bcd     (bcd),
        .take    (take)
    );

    sida_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .status    (status),
        .bcd       (bcd),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (char_code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(sida_pkg::M_TDATA_BITS - sida_pkg::CHAR_BITS){1'b0}}, char_code};

endmodule

>>> hdl/sida_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle
module sida_dabble #(
    parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT,
    parameter int DIGITS     = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [VALUE_BITS-1:0]                 number,
    output logic                                  ready,
    output sida_pkg::conv_status_t                status,
    output logic [DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd,
    input  logic                                  take
);

    localparam int BCD_BITS = DIGITS * sida_pkg::DIGIT_BITS;
    localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_DONE = 3'b100
    } conv_state_t;

    conv_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [BCD_BITS-1:0]   bcd_adj;

    // Correct every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] >= 4'd5) begin
                bcd_adj[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] =
                    bcd_reg[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] + 4'd3;
            end else begin
                bcd_adj[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS] =
                    bcd_reg[i*sida_pkg::DIGIT_BITS +: sida_pkg::DIGIT_BITS];
            end
        end
    end

    // Load the magnitude, shift it into the digits, then hold until handed over
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            CV_IDLE: begin
                if (start) begin
                    neg_next   = number[VALUE_BITS-1];
                    mag_next   = number[VALUE_BITS-1] ? (~number + 1'b1) : number;
                    bcd_next   = '0;
                    cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                    state_next = CV_RUN;
                end
            end
            CV_RUN: begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE: begin
                if (take) begin
                    state_next = CV_IDLE;
                end
            end
            default: begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign ready           = (state_reg == CV_IDLE);
    assign status.done     = (state_reg == CV_DONE);
    assign status.negative = neg_reg;
    assign bcd             = bcd_reg;

endmodule

>>> hdl/sida_emit.sv
// Character emitter: drops leading zeros, then sends any sign and digits via an output register
module sida_emit #(
    parameter int DIGITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sida_pkg::conv_status_t                 status,
    input  logic [DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd,
    output logic                                   take,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sida_pkg::CHAR_BITS-1:0]         out_char,
    output logic                                   out_last
);

    localparam int BCD_BITS  = DIGITS * sida_pkg::DIGIT_BITS;
    localparam int LEFT_BITS = $clog2(DIGITS + 1);

    typedef enum logic [3:0] {
        EM_IDLE  = 4'b0001,
        EM_SKIP  = 4'b0010,
        EM_SIGN  = 4'b0100,
        EM_DIGIT = 4'b1000
    } emit_state_t;

    emit_state_t                    state_reg, state_next;
    logic [BCD_BITS-1:0]            dig_reg, dig_next;
    logic [LEFT_BITS-1:0]           left_reg, left_next;
    logic                           neg_reg, neg_next;
    logic                           valid_reg, valid_next;
    logic [sida_pkg::CHAR_BITS-1:0] char_reg, char_next;
    logic                           last_reg, last_next;
    logic                           out_free;
    logic [sida_pkg::DIGIT_BITS-1:0] top_digit;

    assign out_free  = !valid_reg || out_ready;
    assign top_digit = dig_reg[BCD_BITS-1 -: sida_pkg::DIGIT_BITS];
    assign take      = (state_reg == EM_IDLE) && status.done;

    // Sequence the characters of one number and refill the output register
    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        left_next  = left_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            EM_IDLE: begin
                if (status.done) begin
                    dig_next   = bcd;
                    left_next  = LEFT_BITS'(DIGITS);
                    neg_next   = status.negative;
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP: begin
                // Drop leading zeros, keeping at least one digit
                if ((top_digit == '0) && (left_reg > LEFT_BITS'(1))) begin
                    dig_next  = {dig_reg[BCD_BITS-sida_pkg::DIGIT_BITS-1:0],
                                 {sida_pkg::DIGIT_BITS{1'b0}}};
                    left_next = left_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = EM_SIGN;
                end else begin
                    state_next = EM_DIGIT;
                end
            end
            EM_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = sida_pkg::ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = sida_pkg::ASCII_ZERO + {2'b00, top_digit};
                    last_next  = (left_reg == LEFT_BITS'(1));
                    dig_next   = {dig_reg[BCD_BITS-sida_pkg::DIGIT_BITS-1:0],
                                  {sida_pkg::DIGIT_BITS{1'b0}}};
                    left_next  = left_reg - 1'b1;
                    if (left_reg == LEFT_BITS'(1)) begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        dig_reg  <= dig_next;
        left_reg <= left_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

>>> hdl/sida_checker.sv
// Port-level checker of the decimal text converter and its bind to the top level
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sida_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic                              m_tlast
);

    logic                           mid_run_reg, mid_run_next;
    logic [sida_pkg::CHAR_BITS-1:0] code;

    assign code = m_tdata[sida_pkg::CHAR_BITS-1:0];

    // Track whether a run of characters has begun but not yet ended
    always_comb begin
        mid_run_next = mid_run_reg;
        if (m_tvalid && m_tready) begin
            mid_run_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_run_reg <= 1'b0;
        end else begin
            mid_run_reg <= mid_run_next;
        end
    end

    // Hold a stalled transaction
    `SIDA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A sign is never the last character of a run
    `SIDA_ASSERT_SAME(a_sign_not_last, aclk, aresetn, m_tvalid && (code == sida_pkg::ASCII_MINUS), !m_tlast)

    // A sign only opens a run
    `SIDA_ASSERT_SAME(a_sign_first, aclk, aresetn, m_tvalid && mid_run_reg, code != sida_pkg::ASCII_MINUS)

    // A zero at the head of a run is the whole text
    `SIDA_ASSERT_SAME(a_no_lead_zero, aclk, aresetn, m_tvalid && !mid_run_reg && (code == sida_pkg::ASCII_ZERO), m_tlast)

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
